/* design/mss_pkg.sv */
// mss_pkg: shared types, constants and step-field helpers of the mash step sequencer
// no dependencies; imported by every module of the block

package mss_pkg;

    // profile layout
    localparam int MAX_STEPS       = 6;
    localparam int MIN_W           = 6;
    localparam int TGT_W           = 7;
    localparam int STEP_W          = 3;
    localparam int MIN_REG_W       = MAX_STEPS * MIN_W;
    localparam int TGT_REG_W       = MAX_STEPS * TGT_W;
    localparam int CFG_DATA_W      = TGT_REG_W;
    localparam int CFG_INDEX_W     = 1;
    localparam int STEP_VALUES_DEF = 12;

    // limits applied to programmed fields
    localparam logic [MIN_W-1:0] MINUTES_CAP = MIN_W'(60);
    localparam logic [TGT_W-1:0] TARGET_CAP  = TGT_W'(100);

    // hold time digits
    localparam int SEC_W = 6;
    localparam logic [SEC_W-1:0] SEC_LAST = SEC_W'(59);
    localparam logic [MIN_W-1:0] MIN_LAST = MIN_W'(59);

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_STEP_MINUTES = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_STEP_TARGETS = 1'b1;

    // input action codes
    localparam logic ACT_BUTTON = 1'b0;
    localparam logic ACT_TICK   = 1'b1;

    typedef struct packed {
        logic              action;
        logic signed [7:0] temperature;
    } t_in_item;

    typedef struct packed {
        logic [TGT_W-1:0]  setpoint;
        logic [STEP_W-1:0] step_index;
        logic              running;
        logic              hold_hours;
        logic [MIN_W-1:0]  hold_minutes;
        logic [SEC_W-1:0]  hold_seconds;
        logic              profile_done;
    } t_out_item;

    // remaining hold time kept as hours/minutes/seconds digits
    typedef struct packed {
        logic             hours;
        logic [MIN_W-1:0] minutes;
        logic [SEC_W-1:0] seconds;
    } t_hold_time;

    // command from the step control to the hold timer
    typedef struct packed {
        logic             en;
        logic             clear;
        logic             arm;
        logic             dec;
        logic [MIN_W-1:0] minutes;
    } t_timer_cmd;

    // hold minutes of one step, capped; steps past the register read as zero
    function automatic logic [MIN_W-1:0] step_minutes(
        input logic [MIN_REG_W-1:0] packed_reg,
        input logic [STEP_W-1:0]    idx
    );
        logic [MIN_W-1:0] v;
        v = '0;
        for (int i = 0; i < MAX_STEPS; i++) begin
            if (idx == STEP_W'(i)) begin
                v = packed_reg[i*MIN_W +: MIN_W];
            end
        end
        return (v > MINUTES_CAP) ? MINUTES_CAP : v;
    endfunction

    // target temperature of one step, capped; steps past the register read as zero
    function automatic logic [TGT_W-1:0] step_target(
        input logic [TGT_REG_W-1:0] packed_reg,
        input logic [STEP_W-1:0]    idx
    );
        logic [TGT_W-1:0] v;
        v = '0;
        for (int i = 0; i < MAX_STEPS; i++) begin
            if (idx == STEP_W'(i)) begin
                v = packed_reg[i*TGT_W +: TGT_W];
            end
        end
        return (v > TARGET_CAP) ? TARGET_CAP : v;
    endfunction

endpackage

/* design/mss_hold_timer.sv */
// mss_hold_timer: hold countdown kept as hours/minutes/seconds digits
// depends on mss_pkg (t_timer_cmd, t_hold_time, digit constants)

module mss_hold_timer
    import mss_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_timer_cmd i_cmd,
    output t_hold_time o_next,
    output logic       o_next_zero
);

    t_hold_time r_time;
    t_hold_time n_time;
    t_hold_time w_base;

    // load value, then one-second decrement, then clear
    always_comb begin
        w_base = r_time;
        if (i_cmd.arm) begin
            if (i_cmd.minutes == MINUTES_CAP) begin
                w_base.hours   = 1'b1;
                w_base.minutes = '0;
            end else begin
                w_base.hours   = 1'b0;
                w_base.minutes = i_cmd.minutes;
            end
            w_base.seconds = SEC_W'(1);
        end

        n_time = w_base;
        if (i_cmd.dec) begin
            if (w_base.seconds != '0) begin
                n_time.seconds = w_base.seconds - SEC_W'(1);
            end else if (w_base.minutes != '0) begin
                n_time.minutes = w_base.minutes - MIN_W'(1);
                n_time.seconds = SEC_LAST;
            end else if (w_base.hours) begin
                n_time.hours   = 1'b0;
                n_time.minutes = MIN_LAST;
                n_time.seconds = SEC_LAST;
            end
        end

        if (i_cmd.clear) begin
            n_time = '0;
        end
    end

    assign o_next      = n_time;
    assign o_next_zero = (n_time == '0);

    // countdown register, moves only when a transaction is processed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time <= '0;
        end else if (i_cmd.en) begin
            r_time <= n_time;
        end
    end

endmodule

/* design/mss_step_ctrl.sv */
// mss_step_ctrl: start latch, step sequencing, heater setpoint and result assembly
// depends on mss_pkg; drives the hold timer (mss_hold_timer) through t_timer_cmd

module mss_step_ctrl
    import mss_pkg::*;
#(
    parameter int STEP_VALUES = STEP_VALUES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  t_in_item             i_item,
    input  logic [MIN_REG_W-1:0] i_minutes_packed,
    input  logic [TGT_REG_W-1:0] i_targets_packed,
    output t_timer_cmd           o_timer_cmd,
    input  t_hold_time           i_hold_next,
    input  logic                 i_next_zero,
    output t_out_item            o_result
);

    localparam int NUM_STEPS = STEP_VALUES / 2;

    logic              r_start_latch;
    logic              r_run;
    logic [STEP_W-1:0] r_step;
    logic              r_counting;

    logic              n_start_latch;
    logic              n_run;
    logic [STEP_W-1:0] n_step;
    logic              n_counting;

    logic                  w_any_prog;
    logic [TGT_W-1:0]      w_target;
    logic signed [TGT_W+1:0] w_temp_x;
    logic signed [TGT_W+1:0] w_tgt_x;
    logic                  w_below;
    logic                  w_reached;
    logic                  w_last_step;
    logic [TGT_W-1:0]      w_setpoint;
    logic                  w_done;

    // any minutes or target programmed among the steps in use
    always_comb begin
        w_any_prog = 1'b0;
        for (int i = 0; i < NUM_STEPS; i++) begin
            if (step_minutes(i_minutes_packed, STEP_W'(i)) != '0 ||
                step_target(i_targets_packed, STEP_W'(i)) != '0) begin
                w_any_prog = 1'b1;
            end
        end
    end

    // temperature against the current target
    assign w_target    = step_target(i_targets_packed, r_step);
    assign w_temp_x    = (TGT_W+2)'(i_item.temperature);
    assign w_tgt_x     = $signed({2'b00, w_target}) ;
    assign w_below     = (w_temp_x < w_tgt_x);
    assign w_reached   = (w_temp_x >= w_tgt_x - (TGT_W+2)'(1));
    assign w_last_step = ((4'(r_step) + 4'd1) >= 4'(NUM_STEPS));

    // hold timer command; a press clears, a tick at target arms and counts down
    always_comb begin
        o_timer_cmd         = '0;
        o_timer_cmd.en      = i_en;
        o_timer_cmd.minutes = step_minutes(i_minutes_packed, r_step);
        if (i_item.action == ACT_BUTTON) begin
            o_timer_cmd.clear = 1'b1;
        end else if (r_run && w_reached) begin
            o_timer_cmd.arm = !r_counting;
            o_timer_cmd.dec = 1'b1;
        end
    end

    // next state and result fields
    always_comb begin
        n_start_latch = r_start_latch;
        n_run         = r_run;
        n_step        = r_step;
        n_counting    = r_counting;
        w_setpoint    = '0;
        w_done        = 1'b0;

        if (i_item.action == ACT_BUTTON) begin
            // press toggles the latch; start only with something programmed
            n_step     = '0;
            n_counting = 1'b0;
            if (!r_start_latch && w_any_prog) begin
                n_start_latch = 1'b1;
                n_run         = 1'b1;
            end else begin
                n_start_latch = 1'b0;
                n_run         = 1'b0;
            end
        end else if (r_run) begin
            if (w_below) begin
                w_setpoint = w_target;
            end
            if (w_reached) begin
                n_counting = 1'b1;
                if (i_next_zero) begin
                    n_counting = 1'b0;
                    if (!w_last_step) begin
                        n_step = r_step + STEP_W'(1);
                    end else begin
                        // last hold over: stop and drop the latch, countdown already zero
                        n_start_latch = 1'b0;
                        n_run         = 1'b0;
                        n_step        = '0;
                        w_done        = 1'b1;
                    end
                end
            end
        end

        o_result.setpoint     = w_setpoint;
        o_result.step_index   = n_step;
        o_result.running      = n_run;
        o_result.hold_hours   = i_hold_next.hours;
        o_result.hold_minutes = i_hold_next.minutes;
        o_result.hold_seconds = i_hold_next.seconds;
        o_result.profile_done = w_done;
    end

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_latch <= 1'b0;
            r_run         <= 1'b0;
            r_step        <= '0;
            r_counting    <= 1'b0;
        end else if (i_en) begin
            r_start_latch <= n_start_latch;
            r_run         <= n_run;
            r_step        <= n_step;
            r_counting    <= n_counting;
        end
    end

endmodule

/* design/mash_step_sequencer.sv */
// mash_step_sequencer: top level of the ramp/soak profile controller
// depends on mss_pkg, mss_step_ctrl and mss_hold_timer
//
// channel  | direction | handshake                  | payload
// input    | in        | i_in_valid / o_in_stall    | i_in_item  (t_in_item)
// result   | out       | o_out_valid / i_out_stall  | o_out_item (t_out_item)
// config   | in        | i_cfg_we, i_cfg_index      | i_cfg_data
//
// one transaction per cycle while the result is not stalled; a result passes through the input
// register, then the step logic into the result register
// reset is synchronous and active low: stopped at step 0, timer cleared, valid flags and configuration zero
// a stalled result holds the result register; the input register still drains into it
// as soon as the result is taken, so input stall follows output stall by one stage

module mash_step_sequencer
    import mss_pkg::*;
#(
    parameter int STEP_VALUES = STEP_VALUES_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  t_in_item               i_in_item,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output t_out_item              o_out_item,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    logic [MIN_REG_W-1:0] r_minutes_packed;
    logic [TGT_REG_W-1:0] r_targets_packed;

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;

    logic       w_advance;
    logic       w_in_accept;
    t_out_item  w_result;
    t_timer_cmd w_timer_cmd;
    t_hold_time w_hold_next;
    logic       w_next_zero;

    // handshake between the two register stages
    assign w_advance   = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !w_advance;
    assign w_in_accept = i_in_valid && !o_in_stall;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_minutes_packed <= '0;
            r_targets_packed <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_STEP_MINUTES: r_minutes_packed <= i_cfg_data[MIN_REG_W-1:0];
                CFG_STEP_TARGETS: r_targets_packed <= i_cfg_data[TGT_REG_W-1:0];
                default:          r_minutes_packed <= r_minutes_packed;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_in_item <= i_in_item;
        end
    end

    mss_step_ctrl #(
        .STEP_VALUES (STEP_VALUES)
    ) u_step_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_en             (w_advance),
        .i_item           (r_in_item),
        .i_minutes_packed (r_minutes_packed),
        .i_targets_packed (r_targets_packed),
        .o_timer_cmd      (w_timer_cmd),
        .i_hold_next      (w_hold_next),
        .i_next_zero      (w_next_zero),
        .o_result         (w_result)
    );

    mss_hold_timer u_hold_timer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_timer_cmd),
        .o_next      (w_hold_next),
        .o_next_zero (w_next_zero)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_item <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule
